>>> sv/bfa_pkg.sv
// Package for the binned flow averager: shared constants, register indexes,
// queue word codes and the reciprocal table used to divide by the bin factor.
// No dependencies.
package bfa_pkg;

    localparam int GRID_ROWS_MAX_DEF = 128;
    localparam int GRID_COLS_MAX_DEF = 256;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int FIELD_BITS = 16;
    localparam int POS_BITS   = 13;
    localparam int AVG_BITS   = 13;
    localparam int CFG_BITS   = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam int QUOT_BITS  = 12;
    localparam int OP_BITS    = 2;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_FACTOR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_ROWS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_COLS = 2'd2;

    localparam logic [4:0]          BIN_FACTOR_RST = 5'd4;
    localparam logic [CFG_BITS-1:0] IMAGE_ROWS_RST = 13'd512;
    localparam logic [CFG_BITS-1:0] IMAGE_COLS_RST = 13'd1024;

    // Kinds of word passed from the front to the back.
    localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_EMPTY = 2'd2;

    localparam logic [AVG_BITS-1:0] AVG_EMPTY_VALUE = 13'h1FE0;
    localparam logic [AVG_BITS-1:0] AVG_POS_MAX     = 13'h0FFF;
    localparam logic [AVG_BITS-1:0] AVG_NEG_MAX     = 13'h1000;

    // floor(2^16 / f); the quotient estimate is at most one low.
    function automatic logic [16:0] recip(input logic [4:0] f);
        logic [16:0] m;
        unique case (f)
            5'd0, 5'd1: m = 17'd65536;
            5'd2:  m = 17'd32768;
            5'd3:  m = 17'd21845;
            5'd4:  m = 17'd16384;
            5'd5:  m = 17'd13107;
            5'd6:  m = 17'd10922;
            5'd7:  m = 17'd9362;
            5'd8:  m = 17'd8192;
            5'd9:  m = 17'd7281;
            5'd10: m = 17'd6553;
            5'd11: m = 17'd5957;
            5'd12: m = 17'd5461;
            5'd13: m = 17'd5041;
            5'd14: m = 17'd4681;
            5'd15: m = 17'd4369;
            5'd16: m = 17'd4096;
            5'd17: m = 17'd3855;
            5'd18: m = 17'd3640;
            5'd19: m = 17'd3449;
            5'd20: m = 17'd3276;
            5'd21: m = 17'd3120;
            5'd22: m = 17'd2978;
            5'd23: m = 17'd2849;
            5'd24: m = 17'd2730;
            5'd25: m = 17'd2621;
            5'd26: m = 17'd2520;
            5'd27: m = 17'd2427;
            5'd28: m = 17'd2340;
            5'd29: m = 17'd2259;
            5'd30: m = 17'd2184;
            5'd31: m = 17'd2114;
        endcase
        return m;
    endfunction

endpackage

>>> sv/bfa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/bfa_fifo.sv
// Short flop-based queue between the front and the back of the averager.
// Uses bfa_pkg for its default depth.
module bfa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bfa_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [PW:0]      r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rptr];
    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
endmodule

>>> sv/bfa_front.sv
// Front of the averager: configuration registers, input acceptance, cell
// lookup (position over bin factor) and grid range check. Uses bfa_pkg.
module bfa_front #(
    parameter int GRID_ROWS_MAX = bfa_pkg::GRID_ROWS_MAX_DEF,
    parameter int GRID_COLS_MAX = bfa_pkg::GRID_COLS_MAX_DEF,
    parameter int AW = 15,
    parameter int EW = 65
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic signed [bfa_pkg::FIELD_BITS-1:0] i_flow_dx,
    input  logic signed [bfa_pkg::FIELD_BITS-1:0] i_flow_dy,
    input  logic signed [bfa_pkg::FIELD_BITS-1:0] i_sample_value,
    input  logic signed [bfa_pkg::POS_BITS-1:0]   i_row_pos,
    input  logic signed [bfa_pkg::POS_BITS-1:0]   i_col_pos,
    input  logic                                i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [bfa_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                i_clear_done,
    output logic                                o_push,
    output logic [EW-1:0]                       o_entry,
    input  logic                                i_full
);
    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_CHK  = 3'd2;
    localparam logic [2:0] F_RNG  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_bin;
    logic [12:0] r_rows, r_cols;

    logic        r_cmd;
    logic [15:0] r_dx, r_dy, r_val;
    logic [12:0] r_row, r_col;
    logic [4:0]  r_f;
    logic [28:0] r_pr, r_pc;
    logic [11:0] r_qr, r_qc;
    logic [EW-1:0] r_entry;

    logic        accept;
    logic [4:0]  f_eff;
    logic [11:0] qe_r, qe_c, q_r, q_c;
    logic [16:0] rem_r, rem_c;
    logic [17:0] span_r, span_c;
    logic        ok_r, ok_c;
    logic [AW-1:0] addr;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == F_IDLE) && i_clear_done;
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_entry = r_entry;
    assign f_eff   = (r_bin == 5'd0) ? 5'd1 : r_bin;

    // The reciprocal estimate is low by at most one; one compare fixes it.
    always_comb begin
        qe_r  = r_pr[27:16];
        qe_c  = r_pc[27:16];
        rem_r = 17'(r_row[11:0]) - 17'(qe_r) * 17'(r_f);
        rem_c = 17'(r_col[11:0]) - 17'(qe_c) * 17'(r_f);
        q_r   = (rem_r >= 17'(r_f)) ? qe_r + 1'b1 : qe_r;
        q_c   = (rem_c >= 17'(r_f)) ? qe_c + 1'b1 : qe_c;
    end

    // In the grid if pos >= 0, index < GRID_*_MAX, (index + 1) * f fits the image.
    always_comb begin
        span_r = (18'(r_qr) + 18'd1) * 18'(r_f);
        span_c = (18'(r_qc) + 18'd1) * 18'(r_f);
        ok_r   = !r_row[12] && ({1'b0, r_qr} < 13'(GRID_ROWS_MAX))
                 && (span_r <= 18'(r_rows));
        ok_c   = !r_col[12] && ({1'b0, r_qc} < 13'(GRID_COLS_MAX))
                 && (span_c <= 18'(r_cols));
        addr   = AW'(r_qr) * AW'(GRID_COLS_MAX) + AW'(r_qc);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_MUL;
            F_MUL:  n_state = F_CHK;
            F_CHK:  n_state = F_RNG;
            F_RNG:  n_state = (!r_cmd && !(ok_r && ok_c)) ? F_IDLE : F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_bin   <= bfa_pkg::BIN_FACTOR_RST;
            r_rows  <= bfa_pkg::IMAGE_ROWS_RST;
            r_cols  <= bfa_pkg::IMAGE_COLS_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bfa_pkg::CFG_BIN_FACTOR: r_bin  <= i_cfg_data[4:0];
                    bfa_pkg::CFG_IMAGE_ROWS: r_rows <= i_cfg_data;
                    bfa_pkg::CFG_IMAGE_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_dx  <= i_flow_dx;
            r_dy  <= i_flow_dy;
            r_val <= i_sample_value[15] ? 16'd0 : i_sample_value;
            r_row <= i_row_pos;
            r_col <= i_col_pos;
        end
        if (r_state == F_MUL) begin
            r_f  <= f_eff;
            r_pr <= 29'(r_row[11:0]) * 29'(bfa_pkg::recip(f_eff));
            r_pc <= 29'(r_col[11:0]) * 29'(bfa_pkg::recip(f_eff));
        end
        if (r_state == F_CHK) begin
            // Reads name the cell directly.
            r_qr <= r_cmd ? r_row[11:0] : q_r;
            r_qc <= r_cmd ? r_col[11:0] : q_c;
        end
        if (r_state == F_RNG) begin
            if (ok_r && ok_c) begin
                r_entry <= {(r_cmd ? bfa_pkg::OP_READ : bfa_pkg::OP_ADD), addr,
                            r_dx, r_dy, r_val};
            end else begin
                r_entry <= {bfa_pkg::OP_EMPTY, AW'(0), r_dx, r_dy, r_val};
            end
        end
    end
endmodule

>>> sv/bfa_back.sv
// Back of the averager: clearing pass, read-modify-write of the cell store,
// bit-serial mean division and the output register. Uses bfa_pkg, bfa_ram.
module bfa_back #(
    parameter int GRID_ROWS_MAX = bfa_pkg::GRID_ROWS_MAX_DEF,
    parameter int GRID_COLS_MAX = bfa_pkg::GRID_COLS_MAX_DEF,
    parameter int COUNT_BITS    = bfa_pkg::COUNT_BITS_DEF,
    parameter int AW = 15,
    parameter int EW = 65
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  logic [EW-1:0]                        i_entry,
    output logic                                 o_pop,
    output logic                                 o_clear_done,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [bfa_pkg::AVG_BITS-1:0]  o_avg_dx,
    output logic signed [bfa_pkg::AVG_BITS-1:0]  o_avg_dy,
    output logic signed [bfa_pkg::AVG_BITS-1:0]  o_avg_value,
    output logic                                 o_cell_empty,
    output logic                                 o_count_saturated
);
    localparam int CELLS = GRID_ROWS_MAX * GRID_COLS_MAX;
    localparam int SB = bfa_pkg::FIELD_BITS + COUNT_BITS;
    localparam int RW = 3 * SB + COUNT_BITS;
    localparam int DW = SB + 2;
    localparam int QB = bfa_pkg::QUOT_BITS;
    localparam int FB = bfa_pkg::FIELD_BITS;

    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_RD   = 3'd2;
    localparam logic [2:0] B_DIV  = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic [3:0]    r_step;
    logic          r_out_valid;

    logic [bfa_pkg::OP_BITS-1:0] r_op;
    logic [AW-1:0]   r_addr;
    logic [FB-1:0]   r_in [3];
    logic            r_empty_cell, r_cnt_sat;
    logic [DW-1:0]   r_rem [3];
    logic [DW-1:0]   r_dsh [3];
    logic [QB-1:0]   r_q [3];
    logic            r_neg [3];
    logic            r_sat [3];
    logic [bfa_pkg::AVG_BITS-1:0] r_avg [3];
    logic            r_out_empty, r_out_sat;

    logic [bfa_pkg::OP_BITS-1:0] h_op;
    logic [RW-1:0]   rdata, wdata;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [COUNT_BITS-1:0] cnt;
    logic [SB-1:0]   sum [3];
    logic [SB-1:0]   new_sum [3];
    logic [SB-1:0]   mag [3];
    logic [DW-1:0]   dvd [3];
    logic [DW-1:0]   den;
    logic [bfa_pkg::AVG_BITS-1:0] res [3];
    logic            cnt_max, out_free;

    assign h_op     = i_entry[EW-1 -: bfa_pkg::OP_BITS];
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_clear_done = (r_state != B_CLR);
    assign out_free = !r_out_valid || i_ready;

    assign cnt     = rdata[RW-1 -: COUNT_BITS];
    assign cnt_max = (cnt == {COUNT_BITS{1'b1}});
    assign den     = DW'({cnt, 4'b0000});

    // Mean in units of 8, rounded, is (2|sum| + 8n) / 16n, one quotient bit a cycle.
    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign sum[k]     = rdata[k*SB +: SB];
        assign new_sum[k] = sum[k] + ((k == 2) ? SB'(r_in[k])
                                     : {{(SB-FB){r_in[k][FB-1]}}, r_in[k]});
        assign mag[k]     = sum[k][SB-1] ? SB'(0) - sum[k] : sum[k];
        assign dvd[k]     = DW'({mag[k], 1'b0}) + DW'({cnt, 3'b000});
        assign res[k]     = r_sat[k] ? (r_neg[k] ? bfa_pkg::AVG_NEG_MAX
                                                 : bfa_pkg::AVG_POS_MAX)
                          : (r_neg[k] ? bfa_pkg::AVG_BITS'(0) - {1'b0, r_q[k]}
                                      : {1'b0, r_q[k]});
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (r_state == B_CLR) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (r_state == B_RD) begin
            if (r_op == bfa_pkg::OP_ADD) begin
                we    = !cnt_max;
                wdata = {cnt + 1'b1, new_sum[2], new_sum[1], new_sum[0]};
            end else begin
                we = 1'b1;
            end
        end
    end

    bfa_ram #(
        .WIDTH (RW),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_entry[EW-bfa_pkg::OP_BITS-1 -: AW]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLR:  if (r_clr_addr == AW'(CELLS - 1)) n_state = B_IDLE;
            B_IDLE: if (!i_empty) begin
                n_state = (h_op == bfa_pkg::OP_EMPTY) ? B_OUT : B_RD;
            end
            B_RD: begin
                if (r_op == bfa_pkg::OP_ADD) begin
                    n_state = B_IDLE;
                end else begin
                    n_state = (cnt == '0) ? B_OUT : B_DIV;
                end
            end
            B_DIV:  if (r_step == 4'(QB - 1)) n_state = B_OUT;
            B_OUT:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == B_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op         <= h_op;
            r_addr       <= i_entry[EW-bfa_pkg::OP_BITS-1 -: AW];
            r_in[0]      <= i_entry[2*FB +: FB];
            r_in[1]      <= i_entry[FB +: FB];
            r_in[2]      <= i_entry[0 +: FB];
            r_empty_cell <= 1'b1;
            r_cnt_sat    <= 1'b0;
        end
        if (r_state == B_RD) begin
            r_empty_cell <= (cnt == '0);
            r_cnt_sat    <= cnt_max;
            r_step       <= '0;
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= sum[k][SB-1];
                r_sat[k] <= dvd[k] >= (den << 12);
                r_rem[k] <= dvd[k];
                r_dsh[k] <= den << (QB - 1);
                r_q[k]   <= '0;
            end
        end
        if (r_state == B_DIV) begin
            r_step <= r_step + 1'b1;
            for (int k = 0; k < 3; k++) begin
                if (r_rem[k] >= r_dsh[k]) begin
                    r_rem[k] <= r_rem[k] - r_dsh[k];
                    r_q[k]   <= {r_q[k][QB-2:0], 1'b1};
                end else begin
                    r_q[k]   <= {r_q[k][QB-2:0], 1'b0};
                end
                r_dsh[k] <= r_dsh[k] >> 1;
            end
        end
        if (r_state == B_OUT && out_free) begin
            r_out_empty <= r_empty_cell;
            r_out_sat   <= r_empty_cell ? 1'b0 : r_cnt_sat;
            r_avg[0]    <= r_empty_cell ? '0 : res[0];
            r_avg[1]    <= r_empty_cell ? '0 : res[1];
            r_avg[2]    <= r_empty_cell ? bfa_pkg::AVG_EMPTY_VALUE : res[2];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_avg_dx          = r_avg[0];
    assign o_avg_dy          = r_avg[1];
    assign o_avg_value       = r_avg[2];
    assign o_cell_empty      = r_out_empty;
    assign o_count_saturated = r_out_sat;
endmodule

>>> sv/binned_flow_averager_top.sv
// Top level of the binned flow averager: front, word queue and back.
// Uses bfa_pkg, bfa_front, bfa_fifo, bfa_back.
//
// After reset the cell store is cleared one cell a cycle, all GRID_ROWS_MAX *
// GRID_COLS_MAX cells (32768 at the defaults), and o_ready stays low until
// that pass is done. The front takes one word at a time through accept,
// reciprocal multiply, quotient correction, range check and queue push. In
// the back an add reads the store, then writes the cell back; a read of a
// non-empty cell runs the 12-step bit-serial division of the three means.
// A four-word queue lets the front take new words while the back is busy.
module binned_flow_averager_top #(
    parameter int GRID_ROWS_MAX = bfa_pkg::GRID_ROWS_MAX_DEF,
    parameter int GRID_COLS_MAX = bfa_pkg::GRID_COLS_MAX_DEF,
    parameter int COUNT_BITS    = bfa_pkg::COUNT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_cmd,
    input  logic signed [bfa_pkg::FIELD_BITS-1:0] i_flow_dx,
    input  logic signed [bfa_pkg::FIELD_BITS-1:0] i_flow_dy,
    input  logic signed [bfa_pkg::FIELD_BITS-1:0] i_sample_value,
    input  logic signed [bfa_pkg::POS_BITS-1:0]   i_row_pos,
    input  logic signed [bfa_pkg::POS_BITS-1:0]   i_col_pos,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [bfa_pkg::AVG_BITS-1:0]   o_avg_dx,
    output logic signed [bfa_pkg::AVG_BITS-1:0]   o_avg_dy,
    output logic signed [bfa_pkg::AVG_BITS-1:0]   o_avg_value,
    output logic                                  o_cell_empty,
    output logic                                  o_count_saturated,
    input  logic                                  i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [bfa_pkg::CFG_BITS-1:0]          i_cfg_data
);
    localparam int CELLS = GRID_ROWS_MAX * GRID_COLS_MAX;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int EW = bfa_pkg::OP_BITS + AW + 3 * bfa_pkg::FIELD_BITS;

    logic          push, full, pop, empty, clear_done;
    logic [EW-1:0] push_word, head_word;

    bfa_front #(
        .GRID_ROWS_MAX (GRID_ROWS_MAX),
        .GRID_COLS_MAX (GRID_COLS_MAX),
        .AW            (AW),
        .EW            (EW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_flow_dx      (i_flow_dx),
        .i_flow_dy      (i_flow_dy),
        .i_sample_value (i_sample_value),
        .i_row_pos      (i_row_pos),
        .i_col_pos      (i_col_pos),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_clear_done   (clear_done),
        .o_push         (push),
        .o_entry        (push_word),
        .i_full         (full)
    );

    bfa_fifo #(
        .WIDTH (EW),
        .DEPTH (bfa_pkg::FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_word),
        .o_empty (empty)
    );

    bfa_back #(
        .GRID_ROWS_MAX (GRID_ROWS_MAX),
        .GRID_COLS_MAX (GRID_COLS_MAX),
        .COUNT_BITS    (COUNT_BITS),
        .AW            (AW),
        .EW            (EW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_entry           (head_word),
        .o_pop             (pop),
        .o_clear_done      (clear_done),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_avg_dx          (o_avg_dx),
        .o_avg_dy          (o_avg_dy),
        .o_avg_value       (o_avg_value),
        .o_cell_empty      (o_cell_empty),
        .o_count_saturated (o_count_saturated)
    );

    // No word may enter while the store is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> clear_done)
        else $error("word accepted during clearing pass");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    // An empty cell always reports the fixed empty pattern.
    a_empty_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cell_empty) |-> (o_avg_value == bfa_pkg::AVG_EMPTY_VALUE)
            && (o_avg_dx == '0) && (o_avg_dy == '0) && !o_count_saturated)
        else $error("empty cell result malformed");
endmodule
